### src/mtg_pkg.sv
// Shared types, constant sets and state encodings of the twisted GFSR generator.
package mtg_pkg;

  // Variant select codes.
  typedef logic [1:0] variant_t;
  localparam variant_t VARIANT_MT11213A = 2'd0;
  localparam variant_t VARIANT_MT11213B = 2'd1;
  localparam variant_t VARIANT_MT19937  = 2'd2;
  localparam variant_t VARIANT_TT800    = 2'd3;

  // Input item kinds.
  localparam logic KIND_DRAW = 1'b0;
  localparam logic KIND_SEED = 1'b1;

  // Seed fill multiplier.
  localparam logic [16:0] SEED_MULT = 17'd69069;

  // Per-variant word count and middle offset before clipping to the store size.
  localparam int unsigned VAR_N [4] = '{351, 351, 624, 25};
  localparam int unsigned VAR_M [4] = '{175, 175, 397, 7};

  // Lower-bit mask of the twist (r low bits set), twist constant and tempering.
  localparam logic [31:0] VAR_LOWER [4] = '{32'h0007_ffff, 32'h0007_ffff,
                                            32'h7fff_ffff, 32'h0000_0000};
  localparam logic [31:0] VAR_A [4] = '{32'he4bd_75f5, 32'hccab_8ee7,
                                        32'h9908_b0df, 32'h8ebf_d028};
  localparam logic [31:0] VAR_B [4] = '{32'h655e_5280, 32'h31b6_ab00,
                                        32'h9d2c_5680, 32'h2b5b_2500};
  localparam logic [31:0] VAR_C [4] = '{32'hffd5_8000, 32'hffe5_0000,
                                        32'hefc6_0000, 32'hdb8b_0000};
  localparam logic [4:0]  VAR_U [4] = '{5'd11, 5'd11, 5'd11, 5'd0};
  localparam logic [4:0]  VAR_L [4] = '{5'd17, 5'd17, 5'd18, 5'd16};

  // Fixed tempering shifts.
  localparam logic [4:0] TEMPER_SHIFT_B = 5'd7;
  localparam logic [4:0] TEMPER_SHIFT_C = 5'd15;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEED,
    ST_RD1,
    ST_RD2,
    ST_TEMPER,
    ST_DONE
  } state_t;

  // Tempering steps, one per pass through the shared shift unit.
  typedef enum logic [1:0] {
    TS_U,
    TS_B,
    TS_C,
    TS_L
  } temper_step_t;

endpackage

### src/mtg_ifs.sv
// Valid/ready channel interfaces for the generator's input, result and configuration ports.
interface mtg_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [31:0] seed_value;

  modport source (output valid, output kind, output seed_value, input ready);
  modport sink (input valid, input kind, input seed_value, output ready);
endinterface

interface mtg_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] random_word;

  modport source (output valid, output random_word, input ready);
  modport sink (input valid, input random_word, output ready);
endinterface

interface mtg_cfg_if;
  logic               valid;
  logic               ready;
  mtg_pkg::variant_t  variant;

  modport source (output valid, output variant, input ready);
  modport sink (input valid, input variant, output ready);
endinterface

### src/mersenne_twister_generator_core.sv
// Mersenne Twister family generator core: word store, twist sequencer and tempering unit.
//
//   Channel   Dir   Payload              Beat taken when
//   in_ch     in    kind, seed_value     valid && ready
//   out_ch    out   random_word          valid && ready
//   cfg_ch    in    variant              valid && ready (ready is always high)
//
// A draw runs from its input beat to the result register in these steps: words k and k+1 are
// read at the beat itself, then word k+m is read, the new word is written, four tempering
// passes run through the shared shift/xor unit and the output register is loaded.
// A seed writes all MAX_WORDS store words, one store write and one 32x17 multiply per cycle.
// Reset clears the sequencer, the position and the seeded flag; until the first seed every
// stored word reads as zero, so no clearing pass is run.
// A result waiting on out_ch holds the next draw in its final cycle only.
module mersenne_twister_generator_core #(
  parameter int unsigned MAX_WORDS = 624
) (
  input  logic       clk,
  input  logic       rst_n,
  mtg_in_if.sink     in_ch,
  mtg_out_if.source  out_ch,
  mtg_cfg_if.sink    cfg_ch
);

  localparam int unsigned AW = $clog2(MAX_WORDS);

  // Word counts clipped to the store and middle offsets reduced by them.
  localparam int unsigned NE0 = (mtg_pkg::VAR_N[0] < MAX_WORDS) ? mtg_pkg::VAR_N[0] : MAX_WORDS;
  localparam int unsigned NE1 = (mtg_pkg::VAR_N[1] < MAX_WORDS) ? mtg_pkg::VAR_N[1] : MAX_WORDS;
  localparam int unsigned NE2 = (mtg_pkg::VAR_N[2] < MAX_WORDS) ? mtg_pkg::VAR_N[2] : MAX_WORDS;
  localparam int unsigned NE3 = (mtg_pkg::VAR_N[3] < MAX_WORDS) ? mtg_pkg::VAR_N[3] : MAX_WORDS;
  localparam int unsigned ME0 = mtg_pkg::VAR_M[0] % NE0;
  localparam int unsigned ME1 = mtg_pkg::VAR_M[1] % NE1;
  localparam int unsigned ME2 = mtg_pkg::VAR_M[2] % NE2;
  localparam int unsigned ME3 = mtg_pkg::VAR_M[3] % NE3;

  // Word store.
  logic [31:0] mem [MAX_WORDS];
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [31:0]   mem_wdata;
  logic [AW-1:0] rd_addr_a;
  logic [AW-1:0] rd_addr_b;
  logic [31:0]   rdata_a_r;
  logic [31:0]   rdata_b_r;

  // Control and datapath registers.
  mtg_pkg::state_t       state_r, state_nxt;
  mtg_pkg::temper_step_t step_r, step_nxt;
  mtg_pkg::variant_t     variant_r, variant_nxt;
  logic [AW-1:0]         pos_r, pos_nxt;
  logic [AW-1:0]         idx_r, idx_nxt;
  logic [AW-1:0]         k_r, k_nxt;
  logic [AW-1:0]         km_r, km_nxt;
  logic                  seeded_r, seeded_nxt;
  logic [31:0]           s_r, s_nxt;
  logic [31:0]           y_r, y_nxt;
  logic [31:0]           t_r, t_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [31:0]           out_data_r, out_data_nxt;

  // Combinational helpers.
  logic [AW:0]   n_sel;
  logic [AW:0]   m_sel;
  logic [AW:0]   pos_ext;
  logic [AW-1:0] k_c;
  logic [AW:0]   k1_sum;
  logic [AW-1:0] k1_c;
  logic [AW:0]   km_sum;
  logic [AW-1:0] km_c;
  logic [48:0]   seed_prod;
  logic [31:0]   word_k;
  logic [31:0]   word_k1;
  logic [31:0]   word_km;
  logic [31:0]   lower_mask;
  logic [31:0]   twist_w;
  logic [4:0]    sh_amt;
  logic          sh_left;
  logic [31:0]   sh_mask;
  logic [31:0]   sh_val;
  logic          in_beat;
  logic          out_load;

  // Effective word count and middle offset of the selected variant.
  always_comb begin
    case (variant_r)
      mtg_pkg::VARIANT_MT11213A: begin
        n_sel = (AW+1)'(NE0);
        m_sel = (AW+1)'(ME0);
      end
      mtg_pkg::VARIANT_MT11213B: begin
        n_sel = (AW+1)'(NE1);
        m_sel = (AW+1)'(ME1);
      end
      mtg_pkg::VARIANT_MT19937: begin
        n_sel = (AW+1)'(NE2);
        m_sel = (AW+1)'(ME2);
      end
      default: begin
        n_sel = (AW+1)'(NE3);
        m_sel = (AW+1)'(ME3);
      end
    endcase
  end

  // Word indexes of a draw; a stale position past the count restarts at zero.
  always_comb begin
    pos_ext = {1'b0, pos_r};
    k_c     = (pos_ext >= n_sel) ? '0 : pos_r;
    k1_sum  = {1'b0, k_c} + (AW+1)'(1);
    k1_c    = (k1_sum >= n_sel) ? '0 : k1_sum[AW-1:0];
    km_sum  = {1'b0, k_c} + m_sel;
    km_c    = (km_sum >= n_sel) ? AW'(km_sum - n_sel) : km_sum[AW-1:0];
  end

  // Seed fill multiplier.
  assign seed_prod = s_r * mtg_pkg::SEED_MULT;

  // Stored words read as zero until the first seed.
  assign word_k     = seeded_r ? rdata_a_r : '0;
  assign word_k1    = seeded_r ? rdata_b_r : '0;
  assign word_km    = seeded_r ? rdata_a_r : '0;
  assign lower_mask = mtg_pkg::VAR_LOWER[variant_r];
  assign twist_w    = word_km ^ (y_r >> 1) ^ (y_r[0] ? mtg_pkg::VAR_A[variant_r] : '0);

  // Shared tempering unit: one shift, mask and xor per step.
  always_comb begin
    case (step_r)
      mtg_pkg::TS_U: begin
        sh_amt  = mtg_pkg::VAR_U[variant_r];
        sh_left = 1'b0;
        sh_mask = (mtg_pkg::VAR_U[variant_r] != '0) ? '1 : '0;
      end
      mtg_pkg::TS_B: begin
        sh_amt  = mtg_pkg::TEMPER_SHIFT_B;
        sh_left = 1'b1;
        sh_mask = mtg_pkg::VAR_B[variant_r];
      end
      mtg_pkg::TS_C: begin
        sh_amt  = mtg_pkg::TEMPER_SHIFT_C;
        sh_left = 1'b1;
        sh_mask = mtg_pkg::VAR_C[variant_r];
      end
      default: begin
        sh_amt  = mtg_pkg::VAR_L[variant_r];
        sh_left = 1'b0;
        sh_mask = '1;
      end
    endcase
    sh_val = sh_left ? (t_r << sh_amt) : (t_r >> sh_amt);
  end

  assign in_ch.ready  = (state_r == mtg_pkg::ST_IDLE);
  assign in_beat      = in_ch.valid && in_ch.ready;
  assign out_load     = (state_r == mtg_pkg::ST_DONE) && (!out_valid_r || out_ch.ready);
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid       = out_valid_r;
  assign out_ch.random_word = out_data_r;

  // Sequencer: next state, store accesses and datapath updates.
  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    variant_nxt   = variant_r;
    pos_nxt       = pos_r;
    idx_nxt       = idx_r;
    k_nxt         = k_r;
    km_nxt        = km_r;
    seeded_nxt    = seeded_r;
    s_nxt         = s_r;
    y_nxt         = y_r;
    t_nxt         = t_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    mem_we        = 1'b0;
    mem_waddr     = k_r;
    mem_wdata     = twist_w;
    rd_addr_a     = k_c;
    rd_addr_b     = k1_c;

    if (cfg_ch.valid) begin
      variant_nxt = cfg_ch.variant;
    end

    if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      mtg_pkg::ST_IDLE: begin
        if (in_beat) begin
          if (in_ch.kind == mtg_pkg::KIND_SEED) begin
            s_nxt     = in_ch.seed_value;
            idx_nxt   = '0;
            state_nxt = mtg_pkg::ST_SEED;
          end else begin
            k_nxt     = k_c;
            km_nxt    = km_c;
            state_nxt = mtg_pkg::ST_RD1;
          end
        end
      end
      mtg_pkg::ST_SEED: begin
        mem_we    = 1'b1;
        mem_waddr = idx_r;
        mem_wdata = s_r;
        s_nxt     = seed_prod[31:0];
        idx_nxt   = idx_r + AW'(1);
        if (idx_r == AW'(MAX_WORDS - 1)) begin
          pos_nxt    = '0;
          seeded_nxt = 1'b1;
          state_nxt  = mtg_pkg::ST_IDLE;
        end
      end
      mtg_pkg::ST_RD1: begin
        y_nxt     = (word_k & ~lower_mask) | (word_k1 & lower_mask);
        rd_addr_a = km_r;
        state_nxt = mtg_pkg::ST_RD2;
      end
      mtg_pkg::ST_RD2: begin
        mem_we    = 1'b1;
        t_nxt     = twist_w;
        pos_nxt   = (({1'b0, k_r} + (AW+1)'(1)) >= n_sel) ? '0 : k_r + AW'(1);
        step_nxt  = mtg_pkg::TS_U;
        state_nxt = mtg_pkg::ST_TEMPER;
      end
      mtg_pkg::ST_TEMPER: begin
        t_nxt = t_r ^ (sh_val & sh_mask);
        case (step_r)
          mtg_pkg::TS_U: step_nxt = mtg_pkg::TS_B;
          mtg_pkg::TS_B: step_nxt = mtg_pkg::TS_C;
          mtg_pkg::TS_C: step_nxt = mtg_pkg::TS_L;
          default: begin
            step_nxt  = mtg_pkg::TS_U;
            state_nxt = mtg_pkg::ST_DONE;
          end
        endcase
      end
      mtg_pkg::ST_DONE: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = t_r;
          state_nxt     = mtg_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = mtg_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mtg_pkg::ST_IDLE;
      step_r      <= mtg_pkg::TS_U;
      variant_r   <= mtg_pkg::VARIANT_MT19937;
      pos_r       <= '0;
      seeded_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      variant_r   <= variant_nxt;
      pos_r       <= pos_nxt;
      seeded_r    <= seeded_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    k_r        <= k_nxt;
    km_r       <= km_nxt;
    s_r        <= s_nxt;
    y_r        <= y_nxt;
    t_r        <= t_nxt;
    out_data_r <= out_data_nxt;
  end

  // Word store: one write port, two registered read ports.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_a_r <= mem[rd_addr_a];
    rdata_b_r <= mem[rd_addr_b];
  end

  // The position always names a word inside the store.
  a_pos_in_store: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, pos_r} < (AW+1)'(MAX_WORDS)))
    else $error("position outside the word store");

  // A draw leaves the write cycle and reaches the output load after four tempering passes.
  a_temper_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mtg_pkg::ST_RD2) |-> ##5 (state_r == mtg_pkg::ST_DONE))
    else $error("tempering sequence length wrong");

  // A new result appears only when the sequencer finishes a draw.
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == mtg_pkg::ST_DONE))
    else $error("result raised outside the finishing state");

  // Once seeded, the store stays seeded until reset.
  a_seeded_holds: assert property (@(posedge clk) disable iff (!rst_n)
    seeded_r |=> seeded_r)
    else $error("seeded flag dropped");

endmodule

### tb/mersenne_twister_generator_core_test.sv
// Self-checking testbench for the Mersenne Twister family generator core.
module mersenne_twister_generator_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_WORDS = 624;
  localparam int unsigned RANDOM_ITEMS = 450;
  localparam int unsigned MAX_REPORTS = 100;
  // A seed walks the whole store.
  localparam int unsigned SETTLE_CYCLES = MAX_WORDS + 32;
  localparam int unsigned QUIET_LIMIT = 4 * (MAX_WORDS + 64);

  // Constants of one variant.
  typedef struct {
    int unsigned n;
    int unsigned m;
    logic [31:0] lower;
    logic [31:0] a;
    int unsigned u;
    logic [31:0] b;
    logic [31:0] c;
    int unsigned l;
  } twist_params_t;

  typedef struct {
    logic        kind;
    logic [31:0] seed_value;
  } gen_request_t;

  logic clk = 1'b0;
  logic rst_n;

  mtg_in_if  in_if ();
  mtg_out_if out_if ();
  mtg_cfg_if cfg_if ();

  mersenne_twister_generator_core #(
    .MAX_WORDS(MAX_WORDS)
  ) i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  // Generator state as the block should hold it.
  logic [31:0]        gen_words [MAX_WORDS];
  int unsigned        gen_pos;
  mtg_pkg::variant_t  gen_variant;

  gen_request_t gen_requests [$];
  logic [31:0]  expected_words [$];

  bit           idle_on = 1'b1;
  int unsigned  send_wait;
  int unsigned  take_wait;
  int unsigned  quiet_cycles;
  int unsigned  fail_count;
  int unsigned  items_queued;
  int unsigned  seeds_taken;
  int unsigned  draws_taken [4];
  int unsigned  words_checked;
  int unsigned  variant_writes;

  always #4 clk = ~clk;

  function automatic twist_params_t params_of(input mtg_pkg::variant_t v);
    twist_params_t p;
    case (v)
      mtg_pkg::VARIANT_MT11213A: begin
        p = '{351, 175, 32'h0007_ffff, 32'he4bd_75f5, 11, 32'h655e_5280, 32'hffd5_8000, 17};
      end
      mtg_pkg::VARIANT_MT11213B: begin
        p = '{351, 175, 32'h0007_ffff, 32'hccab_8ee7, 11, 32'h31b6_ab00, 32'hffe5_0000, 17};
      end
      mtg_pkg::VARIANT_MT19937: begin
        p = '{624, 397, 32'h7fff_ffff, 32'h9908_b0df, 11, 32'h9d2c_5680, 32'hefc6_0000, 18};
      end
      default: begin
        p = '{25, 7, 32'h0000_0000, 32'h8ebf_d028, 0, 32'h2b5b_2500, 32'hdb8b_0000, 16};
      end
    endcase
    return p;
  endfunction

  // Applies one accepted item to the state copy; a draw queues its tempered word.
  function automatic void advance_generator(input logic kind, input logic [31:0] seed);
    twist_params_t p;
    int unsigned n, m, k, k1, km;
    logic [31:0] s, y, w;
    p = params_of(gen_variant);
    if (kind == mtg_pkg::KIND_SEED) begin
      s = seed;
      for (int i = 0; i < MAX_WORDS; i++) begin
        gen_words[i] = s;
        s = s * 32'd69069;
      end
      gen_pos = 0;
      seeds_taken++;
      return;
    end
    n = (p.n > MAX_WORDS) ? MAX_WORDS : p.n;
    m = p.m % n;
    k = (gen_pos >= n) ? 0 : gen_pos;
    k1 = (k + 1 >= n) ? 0 : k + 1;
    km = (k + m >= n) ? k + m - n : k + m;
    y = (gen_words[k] & ~p.lower) | (gen_words[k1] & p.lower);
    w = gen_words[km] ^ (y >> 1) ^ (y[0] ? p.a : 32'h0);
    gen_words[k] = w;
    gen_pos = k1;
    // Tempering; a zero first shift skips its step.
    if (p.u != 0) w = w ^ (w >> p.u);
    w = w ^ ((w << 7) & p.b);
    w = w ^ ((w << 15) & p.c);
    w = w ^ (w >> p.l);
    expected_words.push_back(w);
    draws_taken[gen_variant]++;
  endfunction

  function automatic int unsigned pick_gap();
    if (!idle_on) return 0;
    return $urandom_range(15, 0);
  endfunction

  // Input driver: one item per beat, a random gap ahead of each while gaps are on.
  always @(posedge clk) begin
    gen_request_t req;
    if (!rst_n) begin
      in_if.valid <= 1'b0;
      send_wait = pick_gap();
    end else begin
      if (in_if.valid && in_if.ready) begin
        advance_generator(in_if.kind, in_if.seed_value);
      end
      if (!in_if.valid || in_if.ready) begin
        if (send_wait > 0) begin
          send_wait--;
          in_if.valid <= 1'b0;
        end else if (gen_requests.size() != 0) begin
          req = gen_requests.pop_front();
          in_if.kind <= req.kind;
          in_if.seed_value <= req.seed_value;
          in_if.valid <= 1'b1;
          send_wait = pick_gap();
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: checks each beat and stalls a random number of cycles per result.
  always @(posedge clk) begin
    logic [31:0] want;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      take_wait = 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        words_checked++;
        if (expected_words.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $error("random_word 0x%08h arrived with no draw outstanding", out_if.random_word);
        end else begin
          want = expected_words.pop_front();
          if (out_if.random_word !== want) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
              $error("random_word mismatch: expected 0x%08h, actual 0x%08h",
                     want, out_if.random_word);
          end
        end
        take_wait = pick_gap();
      end else if (take_wait > 0 && out_if.valid) begin
        take_wait--;
      end
      out_if.ready <= (take_wait == 0);
    end
  end

  // Watchdog on cycles without any beat on any channel.
  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Watchdog: no beat for %0d cycles", quiet_cycles);
        $display("mersenne_twister_generator_core verification failed");
        $finish;
      end
    end
  end

  task automatic queue_item(input logic kind, input logic [31:0] seed);
    gen_requests.push_back('{kind, seed});
    items_queued++;
  endtask

  // Draws with random ignored seed words, now and then broken by a reseed if with_reseeds is set.
  task automatic queue_draws(input int unsigned count, input bit with_reseeds);
    for (int i = 0; i < count; i++) begin
      if (with_reseeds && $urandom_range(24, 0) == 0)
        queue_item(mtg_pkg::KIND_SEED, $urandom());
      else
        queue_item(mtg_pkg::KIND_DRAW, $urandom());
    end
  endtask

  // Waits until all items are taken and all words are back, then lets a seed finish.
  task automatic wait_idle();
    do @(negedge clk);
    while (gen_requests.size() != 0 || in_if.valid || expected_words.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_variant(input mtg_pkg::variant_t v);
    @(posedge clk);
    cfg_if.variant <= v;
    cfg_if.valid <= 1'b1;
    do @(posedge clk);
    while (!cfg_if.ready);
    gen_variant = v;
    variant_writes++;
    cfg_if.valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic start_phase(input mtg_pkg::variant_t v);
    wait_idle();
    idle_on = ($urandom_range(3, 0) != 0);
    write_variant(v);
  endtask

  initial begin
    int unsigned random_start;
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.kind = mtg_pkg::KIND_DRAW;
    in_if.seed_value = 32'h0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.variant = mtg_pkg::VARIANT_MT19937;
    for (int i = 0; i < MAX_WORDS; i++) gen_words[i] = 32'h0;
    gen_pos = 0;
    gen_variant = mtg_pkg::VARIANT_MT19937;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Draws from the all-zero store right after reset.
    queue_item(mtg_pkg::KIND_DRAW, 32'h0);
    queue_item(mtg_pkg::KIND_DRAW, 32'hffff_ffff);
    // A zero seed keeps every word at zero.
    queue_item(mtg_pkg::KIND_SEED, 32'h0);
    queue_item(mtg_pkg::KIND_DRAW, $urandom());
    queue_item(mtg_pkg::KIND_SEED, 32'hffff_ffff);
    queue_item(mtg_pkg::KIND_DRAW, 32'h0);
    queue_item(mtg_pkg::KIND_DRAW, 32'hffff_ffff);

    start_phase(mtg_pkg::VARIANT_MT11213A);
    queue_item(mtg_pkg::KIND_SEED, 32'h0000_0001);
    queue_draws(3, 1'b0);

    start_phase(mtg_pkg::VARIANT_MT11213B);
    queue_item(mtg_pkg::KIND_SEED, $urandom());
    queue_draws(2, 1'b0);

    start_phase(mtg_pkg::VARIANT_TT800);
    queue_item(mtg_pkg::KIND_SEED, 32'h8000_0000);
    queue_draws(2, 1'b0);

    // Variant changed without a new seed: the words carry over.
    start_phase(mtg_pkg::VARIANT_MT19937);
    queue_draws(2, 1'b0);

    random_start = items_queued;

    // Position past the smaller word count must restart at zero.
    start_phase(mtg_pkg::VARIANT_MT11213A);
    queue_item(mtg_pkg::KIND_SEED, $urandom());
    queue_draws(40, 1'b0);
    start_phase(mtg_pkg::VARIANT_TT800);
    queue_draws(30, 1'b1);

    // Random phases: mostly draw runs with random content, some reseeds.
    while (items_queued - random_start < RANDOM_ITEMS) begin
      start_phase(mtg_pkg::variant_t'($urandom_range(3, 0)));
      if ($urandom_range(2, 0) == 0) queue_item(mtg_pkg::KIND_SEED, $urandom());
      queue_draws($urandom_range(50, 5), 1'b1);
    end

    wait_idle();
    if (expected_words.size() != 0) begin
      fail_count++;
      $error("%0d random_word results never arrived", expected_words.size());
    end
    $display("Covered %0d seeds, %0d variant writes and %0d checked words.",
             seeds_taken, variant_writes, words_checked);
    $display("Draws per variant: MT11213A %0d, MT11213B %0d, MT19937 %0d, TT800 %0d.",
             draws_taken[mtg_pkg::VARIANT_MT11213A], draws_taken[mtg_pkg::VARIANT_MT11213B],
             draws_taken[mtg_pkg::VARIANT_MT19937], draws_taken[mtg_pkg::VARIANT_TT800]);
    if (fail_count == 0) begin
      $display("mersenne_twister_generator_core verification clean");
    end else begin
      $display("mersenne_twister_generator_core verification failed");
    end
    $finish;
  end

endmodule

### sim.f
src/mtg_pkg.sv
src/mtg_ifs.sv
src/mersenne_twister_generator_core.sv
tb/mersenne_twister_generator_core_test.sv
